// File: rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helpers shared by the url percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int unsigned MAX_BUFFER_DEFAULT = 256;
    localparam int unsigned MAX_LEN_W          = 9;
    localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 9'd64;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_DEL     = 8'h7F;
    localparam logic [7:0] CHAR_FIRST_PRINT = 8'h20;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_string;
    } upd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        logic       status;
    } upd_out_t;

    // {ok, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: rtl/upd_core.sv
// ----------------------------------------------------------------------------
// upd_core
// Decoder state machine: escape tracking, byte checks and output limit.
// ----------------------------------------------------------------------------
module upd_core #(
    parameter int unsigned MAX_BUFFER = upd_pkg::MAX_BUFFER_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  upd_pkg::upd_in_t              item,
    input  logic [upd_pkg::MAX_LEN_W-1:0] max_length,
    output logic                          res_valid,
    output upd_pkg::upd_out_t             res
);
    import upd_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BUFFER);
    localparam int unsigned CMP_W = (CNT_W + 1 > MAX_LEN_W) ? CNT_W + 1 : MAX_LEN_W;

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_HEX1,
        PH_HEX2,
        PH_ERROR
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       nib_reg, nib_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] cnt_plus;
    logic [4:0]       hex;
    logic [7:0]       cand;
    logic             cand_en;
    logic             refuse;

    always_comb begin
        if (CMP_W'(max_length) > CMP_W'(MAX_BUFFER)) begin
            limit = CMP_W'(MAX_BUFFER);
        end else begin
            limit = CMP_W'(max_length);
        end
    end

    assign cnt_plus = CMP_W'(cnt_reg) + CMP_W'(1);
    assign hex      = hex_nibble(item.char_byte);

    // byte that would be produced this item, if any
    always_comb begin
        cand    = item.char_byte;
        cand_en = 1'b0;
        case (phase_reg)
            PH_NORMAL: begin
                cand_en = (item.char_byte != CHAR_PERCENT);
                if (item.char_byte == CHAR_PLUS) begin
                    cand = CHAR_SPACE;
                end
            end
            PH_HEX2: begin
                cand    = {nib_reg, hex[3:0]};
                cand_en = hex[4];
            end
            default: begin
                cand_en = 1'b0;
            end
        endcase
    end

    assign refuse = (cand < CHAR_FIRST_PRINT) || (cand == CHAR_DEL) || (cnt_plus >= limit);

    always_comb begin
        phase_next     = phase_reg;
        nib_next       = nib_reg;
        cnt_next       = cnt_reg;
        res_valid      = 1'b0;
        res.out_byte   = '0;
        res.byte_valid = 1'b0;
        res.done_res   = 1'b0;
        res.status     = 1'b0;
        if (item.end_of_string) begin
            res_valid    = 1'b1;
            res.done_res = 1'b1;
            res.status   = !((phase_reg == PH_NORMAL) && (cnt_reg != '0));
            phase_next   = PH_NORMAL;
            nib_next     = '0;
            cnt_next     = '0;
        end else begin
            case (phase_reg)
                PH_NORMAL: begin
                    if (!cand_en) begin
                        phase_next = PH_HEX1;
                    end
                end
                PH_HEX1: begin
                    if (hex[4]) begin
                        nib_next   = hex[3:0];
                        phase_next = PH_HEX2;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_HEX2: begin
                    if (!hex[4]) begin
                        phase_next = PH_ERROR;
                    end
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
            if (cand_en) begin
                if (refuse) begin
                    phase_next = PH_ERROR;
                end else begin
                    phase_next     = PH_NORMAL;
                    cnt_next       = cnt_plus[CNT_W-1:0];
                    res_valid      = 1'b1;
                    res.out_byte   = cand;
                    res.byte_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_NORMAL;
            nib_reg   <= '0;
            cnt_reg   <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Pipeline: two registers, input reg and result reg, around the decoder logic.
// Throughput: one character item per cycle unless m_ready stalls; the decoder
// state updates once per item in one pass of logic between the two registers.
// Reset: synchronous active-low aresetn clears the valid flags of both stages,
// the decoder state, and sets max_length to 64.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
    parameter int unsigned MAX_BUFFER = upd_pkg::MAX_BUFFER_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  upd_pkg::upd_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output upd_pkg::upd_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [upd_pkg::MAX_LEN_W-1:0] cfg_data
);
    import upd_pkg::*;

    logic                 in_valid_reg;
    upd_in_t              in_data_reg;
    logic                 m_valid_reg;
    upd_out_t             m_data_reg;
    logic [MAX_LEN_W-1:0] max_length_reg;

    logic     advance;
    logic     res_valid;
    upd_out_t res;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    upd_core #(
        .MAX_BUFFER (MAX_BUFFER)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_data_reg),
        .max_length (max_length_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            max_length_reg <= MAX_LENGTH_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (!m_valid_reg || m_ready) begin
                m_valid_reg <= advance && res_valid;
            end
            if (cfg_valid) begin
                max_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance && res_valid) begin
            m_data_reg <= res;
        end
    end

endmodule
